[hw/rtl/gmt_pkg.sv]
// Shared types, constants and codes of the group membership table.
package gmt_pkg;

    localparam int GROUP_SLOTS  = 64;
    localparam int MEMBER_SLOTS = 16;
    localparam int GSLOT_W      = $clog2(GROUP_SLOTS);
    localparam int MIDX_W       = $clog2(MEMBER_SLOTS);
    localparam int CNT_W        = 5;
    localparam int MADDR_W      = GSLOT_W + MIDX_W;

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_DESTROY = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_ADD     = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;
    localparam logic [2:0] OP_NOP     = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EXISTS     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] group_key;
        logic [31:0] member_key;
        logic [31:0] member_ip;
        logic [15:0] member_port;
    } cmd_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] ip;
        logic [15:0] port;
    } member_t;

endpackage

[hw/rtl/gmt_front.sv]
// Command intake: decodes the mode and holds words in a two-entry queue.
module gmt_front
    import gmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] group_key,
    input  logic [31:0] member_key,
    input  logic [31:0] member_ip,
    input  logic [15:0] member_port,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t        q_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  fill_reg, fill_next;
    cmd_t        in_cmd;
    logic        push, pop;

    always_comb
    begin
        in_cmd.group_key   = group_key;
        in_cmd.member_key  = member_key;
        in_cmd.member_ip   = member_ip;
        in_cmd.member_port = member_port;
        unique case (mode)
            OP_CREATE:  in_cmd.op = OP_CREATE;
            OP_DESTROY: in_cmd.op = OP_DESTROY;
            OP_LOOKUP:  in_cmd.op = OP_LOOKUP;
            OP_ADD:     in_cmd.op = OP_ADD;
            OP_REMOVE:  in_cmd.op = OP_REMOVE;
            default:    in_cmd.op = OP_NOP;
        endcase
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

[hw/rtl/gmt_back.sv]
// Command engine: group search, member list edits and the result register.
module gmt_back
    import gmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic [CNT_W-1:0] member_limit,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic             member_valid,
    output logic [31:0]      out_member_key,
    output logic [31:0]      out_member_ip,
    output logic [15:0]      out_member_port,
    output logic [4:0]       group_size,
    output logic             last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_CNT_RD   = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_ADD_RD   = 4'd5;
    localparam logic [3:0] S_ADD_WR   = 4'd6;
    localparam logic [3:0] S_ADD_HEAD = 4'd7;
    localparam logic [3:0] S_RM_RD    = 4'd8;
    localparam logic [3:0] S_RM_CMP   = 4'd9;
    localparam logic [3:0] S_SH_RD    = 4'd10;
    localparam logic [3:0] S_SH_WR    = 4'd11;
    localparam logic [3:0] S_RM_DONE  = 4'd12;
    localparam logic [3:0] S_LK_RD    = 4'd13;
    localparam logic [3:0] S_LK_OUT   = 4'd14;

    localparam logic [GSLOT_W-1:0] LAST_SLOT = GSLOT_W'(GROUP_SLOTS - 1);
    localparam logic [CNT_W-1:0]   SLOT_CAP  = CNT_W'(MEMBER_SLOTS);

    logic [31:0]      gid_mem [GROUP_SLOTS];
    logic [CNT_W-1:0] cnt_mem [GROUP_SLOTS];
    member_t          mem [GROUP_SLOTS * MEMBER_SLOTS];
    logic [GROUP_SLOTS-1:0] used_reg, used_next;

    logic [31:0]      gid_q;
    logic [CNT_W-1:0] cnt_q;
    member_t          mem_q;

    logic [3:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [GSLOT_W-1:0] idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [GSLOT_W-1:0] slot_reg, slot_next;
    logic               free_reg, free_next;
    logic [GSLOT_W-1:0] fslot_reg, fslot_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg, status_next;
    logic               mvalid_reg, mvalid_next;
    member_t            omem_reg, omem_next;
    logic [4:0]         size_reg, size_next;
    logic               last_reg, last_next;

    logic               gid_re, gid_we, cnt_re, cnt_we, mem_re, mem_we;
    logic [GSLOT_W-1:0] gid_raddr, cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [MADDR_W-1:0] mem_raddr, mem_waddr;
    member_t            mem_wdata;
    logic               out_free;
    logic [CNT_W-1:0]   cap;
    member_t            new_member;

    assign out_free  = !out_valid_reg || out_ready;
    assign cap       = (member_limit > SLOT_CAP) ? SLOT_CAP : member_limit;
    assign cmd_ready = (state_reg == S_IDLE);
    assign new_member.key  = cmd_reg.member_key;
    assign new_member.ip   = cmd_reg.member_ip;
    assign new_member.port = cmd_reg.member_port;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        free_next      = free_reg;
        fslot_next     = fslot_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        mvalid_next    = mvalid_reg;
        omem_next      = omem_reg;
        size_next      = size_reg;
        last_next      = last_reg;
        gid_re         = 1'b0;
        gid_raddr      = idx_reg;
        gid_we         = 1'b0;
        cnt_re         = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = slot_reg;
        cnt_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = {slot_reg, i_reg[MIDX_W-1:0]};
        mem_we         = 1'b0;
        mem_waddr      = {slot_reg, i_reg[MIDX_W-1:0]};
        mem_wdata      = mem_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                gid_re     = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (used_reg[idx_reg] && gid_q == cmd_reg.group_key && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                if (!used_reg[idx_reg] && !free_reg)
                begin
                    free_next  = 1'b1;
                    fslot_next = idx_reg;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_CNT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CNT_RD:
            begin
                cnt_re     = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    mvalid_next    = 1'b0;
                    omem_next      = '0;
                    size_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    n_next         = cnt_q;
                    case (cmd_reg.op)
                        OP_CREATE:
                        begin
                            if (found_reg)
                            begin
                                status_next = ST_EXISTS;
                                size_next   = cnt_q;
                            end
                            else if (!free_reg)
                            begin
                                status_next = ST_TABLE_FULL;
                            end
                            else
                            begin
                                used_next[fslot_reg] = 1'b1;
                                gid_we    = 1'b1;
                                cnt_we    = 1'b1;
                                cnt_waddr = fslot_reg;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (found_reg)
                            begin
                                used_next[slot_reg] = 1'b0;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (!found_reg)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (cnt_q != '0)
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                i_next         = '0;
                                state_next     = S_LK_RD;
                            end
                        end
                        OP_ADD:
                        begin
                            if (!found_reg)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (cnt_q >= cap)
                            begin
                                status_next = ST_FULL;
                                size_next   = cnt_q;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                i_next         = cnt_q;
                                state_next     = (cnt_q == '0) ? S_ADD_HEAD : S_ADD_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (found_reg && cnt_q != '0)
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                i_next         = '0;
                                state_next     = S_RM_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {slot_reg, MIDX_W'(i_reg - 1'b1)};
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                mem_we     = 1'b1;
                i_next     = i_reg - 1'b1;
                state_next = (i_reg == CNT_W'(1)) ? S_ADD_HEAD : S_ADD_RD;
            end
            S_ADD_HEAD:
            begin
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = {slot_reg, {MIDX_W{1'b0}}};
                    mem_wdata      = new_member;
                    cnt_we         = 1'b1;
                    cnt_wdata      = n_reg + 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    mvalid_next    = 1'b0;
                    omem_next      = '0;
                    size_next      = n_reg + 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_RM_CMP;
            end
            S_RM_CMP:
            begin
                if (mem_q.key == cmd_reg.member_key)
                begin
                    state_next = (i_reg + 1'b1 < n_reg) ? S_SH_RD : S_RM_DONE;
                end
                else if (i_reg + 1'b1 == n_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        mvalid_next    = 1'b0;
                        omem_next      = '0;
                        size_next      = n_reg;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {slot_reg, MIDX_W'(i_reg + 1'b1)};
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = (i_reg + CNT_W'(2) < n_reg) ? S_SH_RD : S_RM_DONE;
            end
            S_RM_DONE:
            begin
                if (out_free)
                begin
                    cnt_we         = 1'b1;
                    cnt_wdata      = n_reg - 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    mvalid_next    = 1'b0;
                    omem_next      = '0;
                    size_next      = n_reg - 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LK_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LK_OUT;
            end
            S_LK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    mvalid_next    = 1'b1;
                    omem_next      = mem_q;
                    size_next      = n_reg;
                    last_next      = (i_reg + 1'b1 == n_reg);
                    i_next         = i_reg + 1'b1;
                    state_next     = (i_reg + 1'b1 == n_reg) ? S_IDLE : S_LK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (gid_re)
        begin
            gid_q <= gid_mem[gid_raddr];
        end
        if (gid_we)
        begin
            gid_mem[fslot_reg] <= cmd_reg.group_key;
        end
        if (cnt_re)
        begin
            cnt_q <= cnt_mem[slot_reg];
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        fslot_reg  <= fslot_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        status_reg <= status_next;
        mvalid_reg <= mvalid_next;
        omem_reg   <= omem_next;
        size_reg   <= size_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign member_valid    = mvalid_reg;
    assign out_member_key  = omem_reg.key;
    assign out_member_ip   = omem_reg.ip;
    assign out_member_port = omem_reg.port;
    assign group_size      = size_reg;
    assign last            = last_reg;

endmodule

[hw/rtl/group_membership_table.sv]
// Top level of the group membership table: intake queue, engine and limit register.
// Each word passes through the intake, the group search over the 64 slots (one id
// memory read and compare per slot) and the count read. A lookup then reads and lists
// each member in turn. An add moves each member entry up by one slot, then writes the
// new head. A remove compares entries in turn and, when it finds a match, moves each
// later entry down by one slot and then finishes. Every step that loads the result
// register waits while the previous result has not been taken. The intake queue holds
// two words while the engine works. No clearing pass after reset.
module group_membership_table
    import gmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] group_key,
    input  logic [31:0] member_key,
    input  logic [31:0] member_ip,
    input  logic [15:0] member_port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        member_valid,
    output logic [31:0] out_member_key,
    output logic [31:0] out_member_ip,
    output logic [15:0] out_member_port,
    output logic [4:0]  group_size,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    logic             limit_we;
    logic [CNT_W-1:0] member_limit_reg;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;

    assign cfg_ready = 1'b1;
    assign limit_we  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_limit_reg <= CNT_W'(16);
        end
        else if (limit_we)
        begin
            member_limit_reg <= cfg_data;
        end
    end

    gmt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .group_key   (group_key),
        .member_key  (member_key),
        .member_ip   (member_ip),
        .member_port (member_port),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    gmt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .member_limit    (member_limit_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .member_valid    (member_valid),
        .out_member_key  (out_member_key),
        .out_member_ip   (out_member_ip),
        .out_member_port (out_member_port),
        .group_size      (group_size),
        .last            (last)
    );

    a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && member_valid |-> status == ST_OK)
        else $error("member word with error status");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !member_valid |-> last)
        else $error("status word without last");

    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> group_size <= 5'(MEMBER_SLOTS))
        else $error("group size above slot room");

endmodule

[dv/tb_top.sv]
// Testbench for the group membership table: directed and random commands checked against a predictor.
class gmt_scoreboard;
    typedef struct {
        logic [2:0]  status;
        logic        mvalid;
        logic [31:0] key;
        logic [31:0] ip;
        logic [15:0] port;
        logic [4:0]  size;
        logic        last;
    } result_t;

    bit          used [64];
    logic [31:0] gid [64];
    int          cnt [64];
    logic [31:0] mkey [64][16];
    logic [31:0] mip [64][16];
    logic [15:0] mport [64][16];
    int          limit;
    result_t     pending [$];
    int          errors;

    function new();
        limit = 16;
        errors = 0;
    endfunction

    function int find_group(logic [31:0] g);
        for (int s = 0; s < 64; s++)
            if (used[s] && gid[s] == g)
                return s;
        return -1;
    endfunction

    function void push(logic [2:0] st, logic v, logic [31:0] k, logic [31:0] ip,
                       logic [15:0] pt, int sz, logic l);
        result_t r;
        r.status = st; r.mvalid = v; r.key = k; r.ip = ip; r.port = pt;
        r.size = sz[4:0]; r.last = l;
        pending.push_back(r);
    endfunction

    function int group_count_of(logic [31:0] g);
        int s;
        s = find_group(g);
        return (s < 0) ? -1 : cnt[s];
    endfunction

    function void note_command(logic [2:0] op, logic [31:0] g, logic [31:0] k,
                               logic [31:0] ip, logic [15:0] pt);
        int s;
        int n;
        int i;
        int cap;
        s = find_group(g);
        case (op)
            gmt_pkg::OP_CREATE:
            begin
                if (s >= 0)
                    push(gmt_pkg::ST_EXISTS, 0, 0, 0, 0, cnt[s], 1);
                else
                begin
                    for (s = 0; s < 64; s++)
                        if (!used[s])
                            break;
                    if (s >= 64)
                        push(gmt_pkg::ST_TABLE_FULL, 0, 0, 0, 0, 0, 1);
                    else
                    begin
                        used[s] = 1; gid[s] = g; cnt[s] = 0;
                        push(gmt_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                    end
                end
            end
            gmt_pkg::OP_DESTROY:
            begin
                if (s >= 0)
                    used[s] = 0;
                push(gmt_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
            end
            gmt_pkg::OP_LOOKUP:
            begin
                if (s < 0)
                    push(gmt_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
                else if (cnt[s] == 0)
                    push(gmt_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                else
                    for (i = 0; i < cnt[s]; i++)
                        push(gmt_pkg::ST_OK, 1, mkey[s][i], mip[s][i], mport[s][i],
                             cnt[s], i + 1 == cnt[s]);
            end
            gmt_pkg::OP_ADD:
            begin
                cap = (limit < 16) ? limit : 16;
                if (s < 0)
                    push(gmt_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
                else if (cnt[s] >= cap)
                    push(gmt_pkg::ST_FULL, 0, 0, 0, 0, cnt[s], 1);
                else
                begin
                    for (i = cnt[s]; i > 0; i--)
                    begin
                        mkey[s][i] = mkey[s][i-1];
                        mip[s][i] = mip[s][i-1];
                        mport[s][i] = mport[s][i-1];
                    end
                    mkey[s][0] = k; mip[s][0] = ip; mport[s][0] = pt;
                    cnt[s]++;
                    push(gmt_pkg::ST_OK, 0, 0, 0, 0, cnt[s], 1);
                end
            end
            gmt_pkg::OP_REMOVE:
            begin
                if (s < 0)
                    push(gmt_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
                else
                begin
                    n = cnt[s];
                    for (i = 0; i < n; i++)
                        if (mkey[s][i] == k)
                            break;
                    if (i < n)
                    begin
                        for (; i + 1 < n; i++)
                        begin
                            mkey[s][i] = mkey[s][i+1];
                            mip[s][i] = mip[s][i+1];
                            mport[s][i] = mport[s][i+1];
                        end
                        cnt[s] = n - 1;
                    end
                    push(gmt_pkg::ST_OK, 0, 0, 0, 0, cnt[s], 1);
                end
            end
            default:
                push(gmt_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
        endcase
    endfunction

    function void check_result(logic [2:0] st, logic v, logic [31:0] k, logic [31:0] ip,
                               logic [15:0] pt, logic [4:0] sz, logic l);
        result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected word status=%0d", $time, st);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.status !== st)
        begin
            $display("%0t: status exp %0d got %0d", $time, e.status, st);
            errors++;
        end
        if (e.mvalid !== v)
        begin
            $display("%0t: member_valid exp %0d got %0d", $time, e.mvalid, v);
            errors++;
        end
        if (e.key !== k)
        begin
            $display("%0t: member_key exp %h got %h", $time, e.key, k);
            errors++;
        end
        if (e.ip !== ip)
        begin
            $display("%0t: member_ip exp %h got %h", $time, e.ip, ip);
            errors++;
        end
        if (e.port !== pt)
        begin
            $display("%0t: member_port exp %h got %h", $time, e.port, pt);
            errors++;
        end
        if (e.size !== sz)
        begin
            $display("%0t: group_size exp %0d got %0d", $time, e.size, sz);
            errors++;
        end
        if (e.last !== l)
        begin
            $display("%0t: last exp %0d got %0d", $time, e.last, l);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import gmt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [31:0] group_key;
    logic [31:0] member_key;
    logic [31:0] member_ip;
    logic [15:0] member_port;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        member_valid;
    logic [31:0] out_member_key;
    logic [31:0] out_member_ip;
    logic [15:0] out_member_port;
    logic [4:0]  group_size;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    gmt_scoreboard board;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;
    int          quiet_cycles;
    logic [31:0] group_pool [8];

    group_membership_table uut (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(status, member_valid, out_member_key, out_member_ip,
                               out_member_port, group_size, last);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles > 20000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // hold off the receiver when asked, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [2:0] op, logic [31:0] g, logic [31:0] k,
                             logic [31:0] ip, logic [15:0] pt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mode <= op; group_key <= g; member_key <= k; member_ip <= ip; member_port <= pt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_command(op, g, k, ip, pt);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        drain();
        cfg_valid <= 1;
        cfg_data <= value[4:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        board.limit = value;
        @(posedge clk);
    endtask

    task automatic random_word();
        logic [2:0]  op;
        logic [31:0] g;
        logic [31:0] k;
        int          r;
        r = $urandom_range(99);
        g = ($urandom_range(9) == 0) ? $urandom() : group_pool[$urandom_range(7)];
        k = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(5));
        if (r < 12) op = OP_CREATE;
        else if (r < 18) op = OP_DESTROY;
        else if (r < 38) op = OP_LOOKUP;
        else if (r < 72) op = OP_ADD;
        else if (r < 95) op = OP_REMOVE;
        else op = 3'($urandom_range(7, 5));
        // keep remove ids matching existing members most of the time
        if (op == OP_REMOVE && board.group_count_of(g) > 0 && $urandom_range(2) != 0)
            k = board.mkey[board.find_group(g)][$urandom_range(board.group_count_of(g) - 1)];
        send_word(op, g, k, $urandom(), 16'($urandom()));
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        in_valid = 0; mode = 0; group_key = 0; member_key = 0; member_ip = 0;
        member_port = 0; out_ready = 0; cfg_valid = 0; cfg_data = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; quiet_cycles = 0;
        for (int i = 0; i < 8; i++)
            group_pool[i] = $urandom();
        group_pool[0] = 32'h0; group_pool[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_word(OP_LOOKUP, 32'h0, 0, 0, 0);
        send_word(OP_ADD, 32'h0, 1, 2, 3);
        send_word(OP_CREATE, 32'h0, 0, 0, 0);
        send_word(OP_CREATE, 32'h0, 0, 0, 0);
        send_word(OP_LOOKUP, 32'h0, 0, 0, 0);
        send_word(OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_ADD, 32'h0, 32'h0, 32'h0, 16'h0);
        send_word(OP_ADD, 32'h0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h5AA5);
        send_word(OP_LOOKUP, 32'h0, 0, 0, 0);
        send_word(OP_REMOVE, 32'h0, 32'h1234, 0, 0);
        send_word(OP_REMOVE, 32'h0, 32'h0, 0, 0);
        send_word(OP_REMOVE, 32'h7, 32'h0, 0, 0);
        send_word(OP_DESTROY, 32'h9, 0, 0, 0);
        send_word(OP_CREATE, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(OP_NOP, 0, 0, 0, 0);
        send_word(3'd7, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(OP_DESTROY, 32'h0, 0, 0, 0);
        send_word(OP_LOOKUP, 32'h0, 0, 0, 0);
        // fill one group to the slot capacity and beyond
        for (int i = 0; i < 17; i++)
            send_word(OP_ADD, 32'hFFFF_FFFF, i, ~i, 16'(i));
        send_word(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        // fill the table
        for (int i = 0; i < 64; i++)
            send_word(OP_CREATE, 32'h1000 + i, 0, 0, 0);
        for (int i = 0; i < 64; i++)
            send_word(OP_DESTROY, 32'h1000 + i, 0, 0, 0);

        write_limit(0);
        send_word(OP_CREATE, group_pool[2], 0, 0, 0);
        send_word(OP_ADD, group_pool[2], 5, 5, 5);
        write_limit(31);
        send_word(OP_ADD, group_pool[2], 5, 5, 5);

        // random phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 10) : 0;
            recv_stall_pct = (ph == 2) ? 72 : (ph == 3 ? 10 : 0);
            write_limit((ph == 0) ? 16 : (ph == 1 ? 3 : (ph == 2 ? 8 : 20)));
            if (ph == 2)
                hold_off = 3000;
            for (int i = 0; i < 28; i++)
                random_word();
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
